// ===== rtl/core/itp_pkg.sv =====
`default_nettype none

package itp_pkg;

   localparam int unsigned MAX_FIELD_CHARS = 255;
   localparam logic [7:0]  COUNT_CAP = (MAX_FIELD_CHARS > 255) ? 8'd255 : 8'(MAX_FIELD_CHARS);

   localparam logic ACTION_CHAR = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   localparam logic [1:0] CSR_NUMBER_BASE = 2'd0;
   localparam logic [1:0] CSR_SIGNED_MODE = 2'd1;
   localparam logic [1:0] CSR_UPPER_LIMIT = 2'd2;
   localparam logic [1:0] CSR_LOWER_LIMIT = 2'd3;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;
   localparam logic [5:0] DIGIT_NONE   = 6'd36;

   localparam logic [63:0] SIGNED_MAX = 64'h7fff_ffff_ffff_ffff;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_DIGITS = 2'd1,
      STATUS_RANGE     = 2'd2
   } status_type;

   typedef struct packed {
      logic       action;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [63:0] value_bits;
      logic [7:0]  consumed;
      status_type  status;
   } rsp_type;

   typedef struct packed {
      logic [5:0]  number_base;
      logic        signed_mode;
      logic [63:0] upper_limit;
      logic [63:0] lower_limit;
   } cfg_type;

   typedef struct packed {
      logic [63:0] magnitude;
      logic [7:0]  char_count;
      logic        minus_seen;
      logic        parse_stopped;
      logic        digit_seen;
      logic        range_error;
      logic        first_pending;
   } parse_state_type;

   localparam cfg_type CFG_RESET = '{
      number_base: 6'd10,
      signed_mode: 1'b1,
      upper_limit: 64'h7fff_ffff_ffff_ffff,
      lower_limit: 64'h8000_0000_0000_0000
   };

   localparam parse_state_type PARSE_CLEAR = '{
      magnitude:     64'd0,
      char_count:    8'd0,
      minus_seen:    1'b0,
      parse_stopped: 1'b0,
      digit_seen:    1'b0,
      range_error:   1'b0,
      first_pending: 1'b1
   };

   function automatic logic [5:0] digit_value(input logic [7:0] c);
      logic [5:0] d;
      d = DIGIT_NONE;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = 6'(c - CHAR_ZERO);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d = 6'(c - CHAR_LOWER_A) + 6'd10;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d = 6'(c - CHAR_UPPER_A) + 6'd10;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/itp_step.sv =====
`default_nettype none

module itp_step (
   input  var itp_pkg::cfg_type         cfg,
   input  var itp_pkg::parse_state_type state,
   input  var logic [7:0]               char_code,
   output itp_pkg::parse_state_type     state_next
);

   logic [5:0]  digit;
   logic [63:0] bound;
   logic [69:0] product;
   logic [70:0] sum;
   logic [7:0]  count_next;

   assign digit   = itp_pkg::digit_value(char_code);
   assign product = 70'(state.magnitude) * 70'(cfg.number_base);
   assign sum     = 71'(product) + 71'(digit);

   assign count_next = (state.char_count < itp_pkg::COUNT_CAP) ?
                       state.char_count + 8'd1 : state.char_count;

   // magnitude limit for the current sign
   always_comb begin
      if (cfg.signed_mode) begin
         if (state.minus_seen) begin
            bound = cfg.lower_limit[63] ? 64'd0 - cfg.lower_limit : 64'd0;
         end else begin
            bound = (cfg.upper_limit > itp_pkg::SIGNED_MAX) ?
                    itp_pkg::SIGNED_MAX : cfg.upper_limit;
         end
      end else begin
         bound = cfg.upper_limit;
      end
   end

   always_comb begin
      state_next = state;
      if (!state.parse_stopped) begin
         state_next.first_pending = 1'b0;
         if (state.first_pending && cfg.signed_mode && char_code == itp_pkg::CHAR_MINUS) begin
            state_next.minus_seen = 1'b1;
            state_next.char_count = count_next;
         end else if (digit >= cfg.number_base) begin
            state_next.parse_stopped = 1'b1;
         end else if (sum > 71'(bound)) begin
            state_next.range_error   = 1'b1;
            state_next.parse_stopped = 1'b1;
         end else begin
            state_next.magnitude  = sum[63:0];
            state_next.digit_seen = 1'b1;
            state_next.char_count = count_next;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/integer_text_parser_unit.sv =====
`default_nettype none

// Streaming integer text parser, radix 2 to 36.
// req channel: one transaction per character (action char) and one that
// closes the field (action end). Only the end transaction yields a result.
// rsp channel: value_bits, consumed and status for each closed field.
// csr port: write-only registers number_base, signed_mode, upper_limit and
// lower_limit, written when csr_wr_en is high; the user must write them only
// while no field is in flight, as the block itself does not enforce it.
// An end transaction's result is registered in the output register.
// Throughput: one transaction per cycle unless an end transaction waits;
// the multiply-add-compare on the accumulated magnitude is combinational.
// A stalled rsp transaction holds in the output register; the input
// register keeps taking characters meanwhile, and an end transaction waits
// there until the output register frees, which then stalls req.
// Reset (synchronous) loads the register defaults, clears the parse state
// and empties both registers; req_ready is high on the first cycle after.

module integer_text_parser_unit (
   input  var logic              clock,
   input  var logic              reset,
   input  var logic              req_valid,
   output logic                  req_ready,
   input  var itp_pkg::req_type  req_data,
   output logic                  rsp_valid,
   input  var logic              rsp_ready,
   output itp_pkg::rsp_type      rsp_data,
   input  var logic              csr_wr_en,
   input  var logic [1:0]        csr_index,
   input  var logic [63:0]       csr_wdata
);

   logic                      in_vld_ff, in_vld_in;
   itp_pkg::req_type          in_item_ff, in_item_in;
   itp_pkg::parse_state_type  state_ff, state_in, state_step;
   itp_pkg::cfg_type          cfg_ff, cfg_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   itp_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   logic out_free;
   logic advance;
   logic is_end;

   itp_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .char_code  (in_item_ff.char_code),
      .state_next (state_step)
   );

   assign is_end    = in_item_ff.action == itp_pkg::ACTION_END;
   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign advance   = in_vld_ff && (!is_end || out_free);
   assign req_ready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_item_in = in_item_ff;
      if (req_ready) begin
         in_vld_in  = req_valid;
         in_item_in = req_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = is_end ? itp_pkg::PARSE_CLEAR : state_step;
      end
   end

   always_comb begin
      rsp_vld_in  = rsp_vld_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      if (advance && is_end) begin
         rsp_vld_in = 1'b1;
         if (!state_ff.digit_seen) begin
            rsp_data_in.value_bits = 64'd0;
            rsp_data_in.consumed   = 8'd0;
            rsp_data_in.status     = itp_pkg::STATUS_NO_DIGITS;
         end else if (state_ff.range_error) begin
            rsp_data_in.value_bits = 64'd0;
            rsp_data_in.consumed   = state_ff.char_count;
            rsp_data_in.status     = itp_pkg::STATUS_RANGE;
         end else begin
            rsp_data_in.value_bits = state_ff.minus_seen ?
                                     64'd0 - state_ff.magnitude : state_ff.magnitude;
            rsp_data_in.consumed   = state_ff.char_count;
            rsp_data_in.status     = itp_pkg::STATUS_OK;
         end
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            itp_pkg::CSR_NUMBER_BASE: cfg_in.number_base = csr_wdata[5:0];
            itp_pkg::CSR_SIGNED_MODE: cfg_in.signed_mode = csr_wdata[0];
            itp_pkg::CSR_UPPER_LIMIT: cfg_in.upper_limit = csr_wdata;
            itp_pkg::CSR_LOWER_LIMIT: cfg_in.lower_limit = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         state_ff   <= itp_pkg::PARSE_CLEAR;
         cfg_ff     <= itp_pkg::CFG_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         state_ff   <= state_in;
         cfg_ff     <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/itp_checker.sv =====
`default_nettype none

module itp_checker (
   input var logic              clock,
   input var logic              reset,
   input var logic              req_valid,
   input var logic              req_ready,
   input var itp_pkg::req_type  req_data,
   input var logic              rsp_valid,
   input var logic              rsp_ready,
   input var itp_pkg::rsp_type  rsp_data
);

   // waiting req transaction holds
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("req transaction dropped or changed while waiting");

   // stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction dropped or changed while stalled");

   // pipeline empty after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   // no digits reports zero value and zero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == itp_pkg::STATUS_NO_DIGITS |->
         rsp_data.value_bits == 64'd0 && rsp_data.consumed == 8'd0)
      else $error("no-digits result carries data");

   // range error needs at least one digit and reports zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == itp_pkg::STATUS_RANGE |->
         rsp_data.value_bits == 64'd0 && rsp_data.consumed != 8'd0)
      else $error("range error result malformed");

endmodule

bind integer_text_parser_unit itp_checker u_itp_checker (.*);

`default_nettype wire

// ===== tb/sv/integer_text_parser_unit_test.sv =====
module integer_text_parser_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import itp_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned PHASE_ITEMS  = 30;

   class field_parse_checker;
      cfg_type     regs;
      rsp_type     pending_results[$];
      int unsigned mismatches;
      logic [63:0] magnitude;
      logic [7:0]  char_count;
      bit          minus_taken;
      bit          halted;
      bit          any_digit;
      bit          overflow;
      bit          at_start;

      function new();
         regs.number_base = 6'd10;
         regs.signed_mode = 1'b1;
         regs.upper_limit = SIGNED_MAX;
         regs.lower_limit = ~SIGNED_MAX;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         magnitude = '0;
         char_count = '0;
         minus_taken = 0;
         halted = 0;
         any_digit = 0;
         overflow = 0;
         at_start = 1;
      endfunction

      function void write_reg(logic [1:0] index, logic [63:0] data);
         case (index)
            CSR_NUMBER_BASE: regs.number_base = data[5:0];
            CSR_SIGNED_MODE: regs.signed_mode = data[0];
            CSR_UPPER_LIMIT: regs.upper_limit = data;
            CSR_LOWER_LIMIT: regs.lower_limit = data;
            default: ;
         endcase
      endfunction

      function logic [5:0] char_digit(logic [7:0] c);
         logic [7:0] folded;
         folded = c | 8'h20;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) return 6'(c - CHAR_ZERO);
         if (folded >= CHAR_LOWER_A && folded <= CHAR_LOWER_Z)
            return 6'(folded - CHAR_LOWER_A + 8'd10);
         return DIGIT_NONE;
      endfunction

      function logic [63:0] magnitude_limit(bit negative);
         if (!regs.signed_mode) return regs.upper_limit;
         if (negative) return regs.lower_limit[63] ? 64'd0 - regs.lower_limit : 64'd0;
         return (regs.upper_limit > SIGNED_MAX) ? SIGNED_MAX : regs.upper_limit;
      endfunction

      function void bump_count();
         if (char_count < COUNT_CAP) char_count++;
      endfunction

      function void take_request(req_type item);
         logic [5:0]  d;
         logic [63:0] lim;
         logic [63:0] base;
         rsp_type     r;
         base = 64'(regs.number_base);
         if (item.action == ACTION_END) begin
            if (!any_digit) begin
               r.value_bits = '0;
               r.consumed = '0;
               r.status = STATUS_NO_DIGITS;
            end else if (overflow) begin
               r.value_bits = '0;
               r.consumed = char_count;
               r.status = STATUS_RANGE;
            end else begin
               r.value_bits = minus_taken ? 64'd0 - magnitude : magnitude;
               r.consumed = char_count;
               r.status = STATUS_OK;
            end
            pending_results.push_back(r);
            restart();
            return;
         end
         if (halted) return;
         if (at_start) begin
            at_start = 0;
            if (regs.signed_mode && item.char_code == CHAR_MINUS) begin
               minus_taken = 1;
               bump_count();
               return;
            end
         end
         d = char_digit(item.char_code);
         if (d >= regs.number_base) begin
            halted = 1;
            return;
         end
         lim = magnitude_limit(minus_taken);
         if (lim < 64'(d) || magnitude > (lim - 64'(d)) / base) begin
            overflow = 1;
            halted = 1;
            return;
         end
         magnitude = magnitude * base + 64'(d);
         any_digit = 1;
         bump_count();
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h %0d %0d", $time,
                     got.value_bits, got.consumed, got.status);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         if (got.value_bits !== want.value_bits) begin
            $display("%0t: value_bits expected %h actual %h", $time,
                     want.value_bits, got.value_bits);
            mismatches++;
         end
         if (got.consumed !== want.consumed) begin
            $display("%0t: consumed expected %0d actual %0d", $time,
                     want.consumed, got.consumed);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   field_parse_checker field_checker;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned cycle_count = 0;
   logic [7:0]  field_q[$];

   integer_text_parser_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) field_checker.check_result(rsp_data);
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic send_item(input logic action, input logic [7:0] code);
      int unsigned gap;
      req_type     item;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      item.action = action;
      item.char_code = code;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      field_checker.take_request(item);
   endtask

   task automatic send_field();
      foreach (field_q[i]) send_item(ACTION_CHAR, field_q[i]);
      send_item(ACTION_END, 8'($urandom_range(255)));
   endtask

   task automatic send_text(input string s);
      field_q.delete();
      for (int i = 0; i < s.len(); i++) field_q.push_back(s[i]);
      send_field();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (field_checker.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [63:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      field_checker.write_reg(index, data);
   endtask

   task automatic write_config(input logic [5:0] base, input logic sgn,
                               input logic [63:0] upper, input logic [63:0] lower);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(CSR_NUMBER_BASE, 64'(base));
      write_reg(CSR_SIGNED_MODE, 64'(sgn));
      write_reg(CSR_UPPER_LIMIT, upper);
      write_reg(CSR_LOWER_LIMIT, lower);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int unsigned digit_span();
      if (field_checker.regs.number_base == 0) return 10;
      if (field_checker.regs.number_base > 36) return 36;
      return field_checker.regs.number_base;
   endfunction

   function automatic logic [7:0] digit_char(logic [5:0] d);
      if (d < 10) return CHAR_ZERO + 8'(d);
      return ($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(d) - 8'd10;
   endfunction

   function automatic void push_digits(int unsigned n);
      repeat (n) field_q.push_back(digit_char(6'($urandom_range(digit_span() - 1))));
   endfunction

   function automatic void push_noise(int unsigned n);
      repeat (n) field_q.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void push_value(logic [63:0] v);
      logic [7:0]  text[$];
      logic [63:0] base;
      base = 64'(digit_span());
      do begin
         text.push_front(digit_char(6'(v % base)));
         v = v / base;
      end while (v != 0);
      foreach (text[i]) field_q.push_back(text[i]);
   endfunction

   function automatic void build_field(bit long_zeros);
      int unsigned kind;
      logic [63:0] target;
      logic [63:0] lim;
      bit          neg;
      field_q.delete();
      if (long_zeros) begin
         repeat (COUNT_CAP + $urandom_range(4, 30)) field_q.push_back(CHAR_ZERO);
         push_digits(2);
         return;
      end
      kind = $urandom_range(99);
      neg = field_checker.regs.signed_mode && $urandom_range(1);
      if (neg || $urandom_range(7) == 0) field_q.push_back(CHAR_MINUS);
      if (kind < 45 && digit_span() >= 2) begin
         lim = field_checker.magnitude_limit(neg);
         case ($urandom_range(5))
            0: target = lim;
            1: target = lim - 64'd1;
            2: target = lim + 64'd1;
            3: target = {$urandom, $urandom} >> $urandom_range(63);
            4: target = 64'($urandom_range(1000));
            default: target = {$urandom, $urandom};
         endcase
         if ($urandom_range(9) == 0) field_q.push_back(CHAR_ZERO);
         push_value(target);
         if ($urandom_range(9) == 0) push_digits(1);
         if ($urandom_range(4) == 0) push_noise($urandom_range(1, 3));
      end else if (kind < 70) begin
         push_digits($urandom_range(0, 14));
         if ($urandom_range(3) == 0) push_noise(1);
      end else if (kind < 85) begin
         push_noise($urandom_range(0, 8));
      end else begin
         repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(2))
               0: field_q.push_back(CHAR_MINUS);
               1: push_digits($urandom_range(1, 3));
               default: push_noise(1);
            endcase
         end
      end
   endfunction

   task automatic run_phase(input int unsigned phase, input logic [5:0] base, input logic sgn,
                            input logic [63:0] upper, input logic [63:0] lower);
      int unsigned sent;
      write_config(base, sgn, upper, lower);
      case (phase % 4)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
         default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         build_field(phase == 1 && sent == 0);
         send_field();
         sent += field_q.size() + 1;
         if ($urandom_range(19) == 0) wait_drained();
      end
   endtask

   initial begin
      field_checker = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_NUMBER_BASE;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // small limits so both bounds are hit with short text
      write_config(6'd10, 1'b1, 64'd99, 64'd0 - 64'd50);
      send_text("99");
      send_text("100");
      send_text("-50");
      send_text("-51");
      send_text("");
      send_text("-");
      send_text("5-");
      field_q.delete();
      field_q.push_back(8'h00);
      field_q.push_back(8'hff);
      field_q.push_back(CHAR_ZERO + 8'd1);
      send_field();

      run_phase(0, 6'd10, 1'b1, SIGNED_MAX, ~SIGNED_MAX);
      run_phase(1, 6'd2, 1'b1, '1, 64'd0);
      run_phase(2, 6'd16, 1'b0, '1, ~SIGNED_MAX);
      run_phase(3, 6'd36, 1'b1, 64'd1000, 64'd0 - 64'd1000);
      run_phase(4, 6'd8, 1'b0, 64'd0, '1);
      run_phase(5, 6'd1, 1'b1, {$urandom, $urandom}, 64'd5);
      run_phase(6, 6'd0, 1'b0, {$urandom, $urandom}, {$urandom, $urandom});
      run_phase(7, 6'd63, 1'b1, {$urandom, $urandom} >> $urandom_range(63),
                ~({$urandom, $urandom} >> $urandom_range(63)));
      for (int p = 8; p < 12; p++) begin
         run_phase(p, 6'($urandom_range(2, 36)), 1'($urandom_range(1)),
                   {$urandom, $urandom} >> $urandom_range(60),
                   ~({$urandom, $urandom} >> $urandom_range(60)));
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (field_checker.mismatches == 0 && field_checker.pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/itp_pkg.sv
rtl/core/itp_step.sv
rtl/core/integer_text_parser_unit.sv
rtl/core/itp_checker.sv
tb/sv/integer_text_parser_unit_test.sv
